// ===== rtl/core/isfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfp_pkg
// Shared constants and types for the IMU serial frame parser.
// ----------------------------------------------------------------------------
package isfp_pkg;

    localparam int unsigned POS_WIDTH     = 4;
    localparam int unsigned PAYLOAD_WIDTH = 64;
    localparam int unsigned KIND_WIDTH    = 3;

    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] KIND_FIRST  = 8'h50;
    localparam logic [7:0] KIND_LAST   = 8'h54;

    localparam int unsigned FRAME_LENGTH = 11;

    localparam logic [POS_WIDTH-1:0] POS_HUNT     = POS_WIDTH'(0);
    localparam logic [POS_WIDTH-1:0] POS_KIND     = POS_WIDTH'(1);
    localparam logic [POS_WIDTH-1:0] POS_DATA_FIRST = POS_WIDTH'(2);
    localparam logic [POS_WIDTH-1:0] POS_DATA_LAST  = POS_WIDTH'(FRAME_LENGTH - 2);
    localparam logic [POS_WIDTH-1:0] POS_CHECKSUM = POS_WIDTH'(FRAME_LENGTH - 1);

    typedef struct packed {
        logic                     valid;
        logic [KIND_WIDTH-1:0]    kind;
        logic [PAYLOAD_WIDTH-1:0] payload;
    } frame_result_t;

endpackage

// ===== rtl/core/isfp_frame_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfp_frame_tracker
// Tracks the byte position within a frame, captures the type byte and shifts
// in the payload bytes; flags a finished frame of a known type.
// ----------------------------------------------------------------------------
module isfp_frame_tracker
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_take,
    input  logic [7:0]             rx_byte,
    output logic                   at_checksum,
    output isfp_pkg::frame_result_t result
);

    import isfp_pkg::*;

    logic [POS_WIDTH-1:0]     position_reg;
    logic [POS_WIDTH-1:0]     position_next;
    logic [7:0]               kind_byte_reg;
    logic [7:0]               kind_byte_next;
    logic [PAYLOAD_WIDTH-1:0] payload_shift_reg;
    logic [PAYLOAD_WIDTH-1:0] payload_shift_next;
    logic                     kind_known;

    assign kind_known  = (kind_byte_reg >= KIND_FIRST) && (kind_byte_reg <= KIND_LAST);
    assign at_checksum = (position_reg == POS_CHECKSUM);

    always_comb
    begin
        position_next      = position_reg;
        kind_byte_next     = kind_byte_reg;
        payload_shift_next = payload_shift_reg;
        result.valid       = 1'b0;
        result.kind        = KIND_WIDTH'(kind_byte_reg - KIND_FIRST);
        result.payload     = payload_shift_reg;
        if (byte_take)
        begin
            case (position_reg) inside
                POS_KIND:
                begin
                    kind_byte_next = rx_byte;
                    position_next  = POS_DATA_FIRST;
                end
                [POS_DATA_FIRST:POS_DATA_LAST]:
                begin
                    payload_shift_next = {rx_byte, payload_shift_reg[PAYLOAD_WIDTH-1:8]};
                    position_next      = position_reg + POS_WIDTH'(1);
                end
                POS_CHECKSUM:
                begin
                    position_next = POS_HUNT;
                    result.valid  = kind_known;
                end
                default:
                begin
                    if (rx_byte == HEADER_BYTE)
                    begin
                        position_next      = POS_KIND;
                        payload_shift_next = '0;
                    end
                    else
                    begin
                        position_next = POS_HUNT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg      <= POS_HUNT;
            kind_byte_reg     <= '0;
            payload_shift_reg <= '0;
        end
        else
        begin
            position_reg      <= position_next;
            kind_byte_reg     <= kind_byte_next;
            payload_shift_reg <= payload_shift_next;
        end
    end

endmodule

// ===== rtl/core/isfp_result_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfp_result_reg
// Output register that holds one decoded frame until the downstream side
// takes it.
// ----------------------------------------------------------------------------
module isfp_result_reg
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  isfp_pkg::frame_result_t                result,
    input  logic                                   out_stall,
    output logic                                   out_valid,
    output logic [isfp_pkg::KIND_WIDTH-1:0]        frame_kind,
    output logic [isfp_pkg::PAYLOAD_WIDTH-1:0]     frame_payload
);

    import isfp_pkg::*;

    logic                     valid_reg;
    logic                     valid_next;
    logic [KIND_WIDTH-1:0]    kind_reg;
    logic [PAYLOAD_WIDTH-1:0] payload_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (result.valid)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            kind_reg    <= result.kind;
            payload_reg <= result.payload;
        end
    end

    assign out_valid     = valid_reg;
    assign frame_kind    = kind_reg;
    assign frame_payload = payload_reg;

endmodule

// ===== rtl/core/imu_serial_frame_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_serial_frame_parser
// Assembles 11-byte IMU frames (header 0x55, type, eight payload bytes,
// checksum) from a serial byte stream and emits the known frame types.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock cycle. A decoded frame appears on the
// output the cycle after its checksum byte is accepted and stays there until
// it is taken. Only the byte that would complete a frame is held off while a
// previous result is still waiting, so the position counter and payload shift
// register never stop for any other byte. The checksum byte is not verified.
// ----------------------------------------------------------------------------
module imu_serial_frame_parser
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [7:0]                             rx_byte,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [isfp_pkg::KIND_WIDTH-1:0]        frame_kind,
    output logic [isfp_pkg::PAYLOAD_WIDTH-1:0]     frame_payload
);

    import isfp_pkg::*;

    logic          byte_take;
    logic          at_checksum;
    frame_result_t result;

    assign in_stall  = at_checksum && out_valid && out_stall;
    assign byte_take = in_valid && !in_stall;

    isfp_frame_tracker u_tracker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_take   (byte_take),
        .rx_byte     (rx_byte),
        .at_checksum (at_checksum),
        .result      (result)
    );

    isfp_result_reg u_result
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .result        (result),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .frame_kind    (frame_kind),
        .frame_payload (frame_payload)
    );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the IMU serial frame parser. A behavioral
// decoder follows every accepted byte and queues the frames the parser must
// emit. Each emitted frame is compared field by field with the oldest queued
// one. Directed frames cover header hunting, header bytes inside frames,
// unknown types, all five frame types and the payload extremes. A long random
// stream of valid, unknown, truncated and noisy frames follows, with random
// gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;

    import isfp_pkg::*;

    typedef struct packed {
        logic [KIND_WIDTH-1:0]    kind;
        logic [PAYLOAD_WIDTH-1:0] payload;
    } decoded_frame_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [7:0]               rx_byte;
    logic                     out_valid;
    logic                     out_stall;
    logic [KIND_WIDTH-1:0]    frame_kind;
    logic [PAYLOAD_WIDTH-1:0] frame_payload;

    logic [POS_WIDTH-1:0]     frame_pos;
    logic [7:0]               frame_type;
    logic [PAYLOAD_WIDTH-1:0] payload_acc;
    decoded_frame_t           pending_frames[$];
    decoded_frame_t           oldest_frame;

    int unsigned error_count;
    int unsigned frames_checked;
    int unsigned bytes_sent;
    bit          sender_gaps;
    bit          receiver_stalls;

    imu_serial_frame_parser dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_kind    (frame_kind),
        .frame_payload (frame_payload)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function void decode_rx_byte(input logic [7:0] b);
        decoded_frame_t done_frame;
        if (frame_pos == POS_HUNT || frame_pos >= FRAME_LENGTH)
        begin
            if (b == HEADER_BYTE)
            begin
                frame_pos   = POS_KIND;
                payload_acc = '0;
            end
            else
            begin
                frame_pos = POS_HUNT;
            end
        end
        else if (frame_pos == POS_KIND)
        begin
            frame_type = b;
            frame_pos  = POS_DATA_FIRST;
        end
        else if (frame_pos <= POS_DATA_LAST)
        begin
            payload_acc = {b, payload_acc[PAYLOAD_WIDTH-1:8]};
            frame_pos   = frame_pos + POS_WIDTH'(1);
        end
        else
        begin
            frame_pos = POS_HUNT;
            if (frame_type >= KIND_FIRST && frame_type <= KIND_LAST)
            begin
                done_frame.kind    = KIND_WIDTH'(frame_type - KIND_FIRST);
                done_frame.payload = payload_acc;
                pending_frames.push_back(done_frame);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                decode_rx_byte(rx_byte);
            end
            if (out_valid && !out_stall)
            begin
                if (pending_frames.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("ERROR: unexpected frame kind=%0d payload=%h",
                                 frame_kind, frame_payload);
                    end
                end
                else
                begin
                    oldest_frame = pending_frames.pop_front();
                    frames_checked++;
                    if (frame_kind !== oldest_frame.kind
                        || frame_payload !== oldest_frame.payload)
                    begin
                        error_count++;
                        if (error_count <= 10)
                        begin
                            $display(
                                "ERROR: frame %0d exp kind=%0d data=%h, got kind=%0d data=%h",
                                frames_checked, oldest_frame.kind,
                                oldest_frame.payload, frame_kind, frame_payload);
                        end
                    end
                end
            end
        end
    end

    // The receiver draws a stall length for every transaction.
    initial
    begin
        int unsigned hold_cycles;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold_cycles = receiver_stalls ? $urandom_range(0, 4) : 0;
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (!(out_valid && !out_stall));
        end
    end

    task send_byte(input logic [7:0] b);
        int unsigned gap_cycles;
        gap_cycles = sender_gaps ? $urandom_range(0, 4) : 0;
        if (gap_cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap_cycles) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        bytes_sent++;
    endtask

    task send_frame(input logic [7:0] kind, input logic [PAYLOAD_WIDTH-1:0] payload,
                    input logic [7:0] checksum);
        send_byte(HEADER_BYTE);
        send_byte(kind);
        for (int i = 0; i < 8; i++)
        begin
            send_byte(payload[8*i +: 8]);
        end
        send_byte(checksum);
    endtask

    task wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_frames.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function logic [PAYLOAD_WIDTH-1:0] random_payload();
        logic [PAYLOAD_WIDTH-1:0] payload;
        for (int i = 0; i < 8; i++)
        begin
            payload[8*i +: 8] = ($urandom_range(0, 7) == 0) ? HEADER_BYTE
                                                            : 8'($urandom());
        end
        return payload;
    endfunction

    function logic [7:0] unknown_kind();
        logic [7:0] kind;
        case ($urandom_range(0, 4))
            0: kind = KIND_FIRST - 8'd1;
            1: kind = KIND_LAST + 8'd1;
            2: kind = 8'h00;
            3: kind = 8'hFF;
            default:
            begin
                kind = 8'($urandom());
                if (kind >= KIND_FIRST && kind <= KIND_LAST)
                begin
                    kind = kind ^ 8'h80;
                end
            end
        endcase
        return kind;
    endfunction

    task test_hunting_noise();
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hAA);
        send_byte(HEADER_BYTE + 8'd1);
    endtask

    task test_directed_frames();
        send_frame(KIND_FIRST, {8{HEADER_BYTE}}, HEADER_BYTE);
        send_frame(KIND_FIRST - 8'd1, {PAYLOAD_WIDTH{1'b1}}, 8'h00);
        send_frame(KIND_LAST, 64'h0000_0000_0000_0000, 8'hFF);
        send_frame(HEADER_BYTE, 64'h8877_6655_4433_2211, 8'h01);
    endtask

    task test_drain_pause();
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        send_frame(KIND_FIRST + 8'd2, {PAYLOAD_WIDTH{1'b1}}, 8'hA5);
        wait_for_drain();
        send_frame(KIND_FIRST + 8'd3, 64'h0123_4567_89AB_CDEF, 8'h5A);
        send_frame(KIND_FIRST + 8'd1, 64'hFEDC_BA98_7654_3210, 8'h00);
    endtask

    task test_random_stream();
        int unsigned pick;
        int unsigned count;
        while (bytes_sent < 400)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                sender_gaps     = 1'($urandom_range(0, 1));
                receiver_stalls = 1'($urandom_range(0, 1));
            end
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                send_frame(KIND_FIRST + 8'($urandom_range(0, 4)), random_payload(),
                           8'($urandom()));
            end
            else if (pick < 78)
            begin
                send_frame(unknown_kind(), random_payload(), 8'($urandom()));
            end
            else if (pick < 90)
            begin
                count = $urandom_range(1, 5);
                repeat (count) send_byte(8'($urandom()));
            end
            else
            begin
                count = $urandom_range(1, 9);
                send_byte(HEADER_BYTE);
                repeat (count) send_byte(8'($urandom()));
            end
        end
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        rx_byte         <= 8'h00;
        frame_pos       = POS_HUNT;
        frame_type      = 8'h00;
        payload_acc     = '0;
        error_count     = 0;
        frames_checked  = 0;
        bytes_sent      = 0;
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_hunting_noise();
        test_directed_frames();
        test_drain_pause();
        test_random_stream();

        wait_for_drain();
        repeat (10) @(posedge clk);
        if (error_count == 0 && pending_frames.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        #400000;
        $display("ERROR: timeout");
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/isfp_pkg.sv
rtl/core/isfp_frame_tracker.sv
rtl/core/isfp_result_reg.sv
rtl/core/imu_serial_frame_parser.sv
test/tb_top.sv
